// File: rtl/int_to_radix_ascii_assert.svh
// Assertion macros shared by the radix converter RTL.
`ifndef INT_TO_RADIX_ASCII_ASSERT_SVH
`define INT_TO_RADIX_ASCII_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define ITRA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("int_to_radix_ascii: assertion failed");

// Next-cycle implication, sampled on the rising edge, quiet during reset.
`define ITRA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("int_to_radix_ascii: assertion failed");

`else

`define ITRA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ITRA_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

// File: rtl/itra_pkg.sv
// Types, constants and the digit-to-character function of the radix converter.
`default_nettype none

package itra_pkg;

    // Digits and bases fit in six bits (largest base is 36)
    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned CODE_W  = 8;

    localparam logic [7:0]        MIN_BASE   = 8'd2;
    localparam logic [CODE_W-1:0] MINUS_CODE = 8'h2D;
    localparam logic [CODE_W-1:0] ZERO_CODE  = 8'h30;
    localparam logic [CODE_W-1:0] ALPHA_CODE = 8'h41;
    localparam logic [CODE_W-1:0] ERROR_CODE = 8'h00;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS   = 6'd10;
    localparam logic [DIGIT_W-1:0] TOTAL_DIGITS = 6'd36;

    // Status of the serial divider towards the sequencer
    typedef struct packed {
        logic done;     // quotient and remainder valid this cycle
        logic nonzero;  // quotient has at least one set bit
    } div_status_t;

    // Digit value to ASCII: 0-9 then A-Z, out-of-range reads as '0'
    function automatic logic [CODE_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] code;
        if (d < DEC_DIGITS)
            code = ZERO_CODE + CODE_W'(d);
        else if (d < TOTAL_DIGITS)
            code = ALPHA_CODE + CODE_W'(d - DEC_DIGITS);
        else
            code = ZERO_CODE;
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/itra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itra_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/itra_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, small base divisor.
`default_nettype none

`include "int_to_radix_ascii_assert.svh"

module itra_div
    import itra_pkg::*;
#(
    parameter int unsigned WORD_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [WORD_WIDTH-1:0] dividend,
    input  wire logic [DIGIT_W-1:0]    divisor,
    output logic      [WORD_WIDTH-1:0] quotient,
    output logic      [DIGIT_W-1:0]    remainder,
    output div_status_t                status
);

    localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [DIGIT_W-1:0]    dsr_reg, dsr_next;
    logic                  nz_reg, nz_next;

    // One restoring step: partial remainder never exceeds 2*35+1
    logic [DIGIT_W:0] part_rem;
    logic [DIGIT_W:0] part_diff;
    logic             fits;

    assign part_rem  = {rem_reg, dvd_reg[WORD_WIDTH-1]};
    assign part_diff = part_rem - {1'b0, dsr_reg};
    assign fits      = part_rem >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        nz_next   = nz_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_WIDTH);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            nz_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_WIDTH-2:0], fits};
            rem_next = fits ? part_diff[DIGIT_W-1:0] : part_rem[DIGIT_W-1:0];
            nz_next  = nz_reg | fits;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        nz_reg  <= nz_next;
    end

    assign quotient       = dvd_reg;
    assign remainder      = rem_reg;
    assign status.done    = done_reg;
    assign status.nonzero = nz_reg;

    `ITRA_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, done_reg, rem_reg < dsr_reg)
    `ITRA_ASSERT_NXT(a_start_runs, clk, rst_n, start, busy_reg && !done_reg)
    `ITRA_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

`default_nettype wire

// File: rtl/int_to_radix_ascii.sv
// Top level: signed integer to ASCII string in bases 2..MAX_BASE, one character per word.
// Sequence: a bad base gives its single error word once the output register is free.
// Otherwise each digit takes one pass of the bit-serial divider, then an optional minus
// sign goes out and each character is read from the digit RAM, then registered for output.
// Throughput: one item at a time; the next is taken once the final word is registered.
// Reset (rst_n, asynchronous, active low) clears sequencer, output and divider control registers only.
`default_nettype none

`include "int_to_radix_ascii_assert.svh"

module int_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int unsigned WORD_WIDTH = 32,
    parameter int unsigned MAX_BASE   = 36
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic signed [WORD_WIDTH-1:0] value,
    input  wire logic        [7:0]            base,
    output logic                              char_valid,
    input  wire logic                         char_ready,
    output logic             [CODE_W-1:0]     char_code,
    output logic                              bad_base,
    output logic                              last
);

    localparam int unsigned ADDR_W = $clog2(WORD_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [DIGIT_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   char_code_reg, char_code_next;
    logic                bad_base_reg, bad_base_next;
    logic                last_reg, last_next;

    logic [WORD_WIDTH-1:0] value_u;
    logic [WORD_WIDTH-1:0] value_mag;
    logic                  base_bad;
    logic                  slot_free;

    logic                  div_start;
    logic [WORD_WIDTH-1:0] div_dividend;
    logic [WORD_WIDTH-1:0] div_quot;
    logic [DIGIT_W-1:0]    div_rem;
    div_status_t           div_stat;

    logic                  ram_we;
    logic                  ram_re;
    logic [DIGIT_W-1:0]    ram_rdata;

    // Magnitude of the input word; the most negative value maps to itself unsigned
    assign value_u   = $unsigned(value);
    assign value_mag = value_u[WORD_WIDTH-1] ? (~value_u + WORD_WIDTH'(1)) : value_u;
    assign base_bad  = (base < MIN_BASE) || (base > 8'(MAX_BASE));

    // Output register may be reloaded when empty or being drained
    assign slot_free = !out_valid_reg || char_ready;

    // First division takes the magnitude, later ones the previous quotient
    assign div_dividend = (state_reg == S_IDLE) ? value_mag : div_quot;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        base_next      = base_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        out_valid_next = out_valid_reg && !char_ready;
        char_code_next = char_code_reg;
        bad_base_next  = bad_base_reg;
        last_next      = last_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (base_bad)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        neg_next    = value_u[WORD_WIDTH-1];
                        base_next   = base[DIGIT_W-1:0];
                        wr_ptr_next = '0;
                        div_start   = 1'b1;
                        state_next  = S_DIV;
                    end
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = ERROR_CODE;
                    bad_base_next  = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    ram_we = 1'b1;
                    if (div_stat.nonzero)
                    begin
                        div_start   = 1'b1;
                        wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        rd_ptr_next = wr_ptr_reg;
                        state_next  = neg_reg ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = MINUS_CODE;
                    bad_base_next  = 1'b0;
                    last_next      = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = digit_to_ascii(ram_rdata);
                    bad_base_next  = 1'b0;
                    last_next      = (rd_ptr_reg == '0);
                    if (rd_ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - ADDR_W'(1);
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            char_code_reg <= '0;
            bad_base_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
            char_code_reg <= char_code_next;
            bad_base_reg  <= bad_base_next;
            last_reg      <= last_next;
        end
    end

    // Serial divider: one digit per pass
    itra_div #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_start && (state_reg == S_IDLE) ? base[DIGIT_W-1:0] : base_reg),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_stat)
    );

    // Digit store, least significant first, read back in reverse
    itra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (WORD_WIDTH)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (div_rem),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign char_valid = out_valid_reg;
    assign char_code  = char_code_reg;
    assign bad_base   = bad_base_reg;
    assign last       = last_reg;

    `ITRA_ASSERT_IMP(a_err_word, clk, rst_n, out_valid_reg && bad_base_reg, last_reg && (char_code_reg == ERROR_CODE))
    `ITRA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item_valid && item_ready, !item_ready)
    `ITRA_ASSERT_IMP(a_done_in_div, clk, rst_n, div_stat.done, state_reg == S_DIV)

endmodule

`default_nettype wire
